// File: rtl/core/matrix_keypad_scanner_unit_defines.svh
// assertion macros shared by the keypad scanner rtl
// both expect clk and rst in scope
`ifndef MATRIX_KEYPAD_SCANNER_UNIT_DEFINES_SVH
`define MATRIX_KEYPAD_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication
`define MKS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mks_pkg.sv
`timescale 1ns / 1ps
package mks_pkg;

  localparam int TABLE_DIM   = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE_MS      = 3'd0,
    REG_COLUMN_PIN_ZERO  = 3'd1,
    REG_COLUMN_PIN_ONE   = 3'd2,
    REG_COLUMN_PIN_TWO   = 3'd3,
    REG_COLUMN_PIN_THREE = 3'd4
  } cfg_reg_t;

  localparam logic [15:0] DEBOUNCE_MS_RESET = 16'd200;
  localparam logic [TABLE_DIM-1:0][15:0] COLUMN_PIN_RESET = {16'd8, 16'd4, 16'd2, 16'd1};

  typedef struct packed {
    logic        mode;
    logic [15:0] pin_code;
    logic [31:0] time_ms;
    logic [3:0]  row_sense;
  } in_t;

  typedef struct packed {
    logic       event_taken;
    logic       key_valid;
    logic [7:0] key_code;
    logic       key_pending;
  } out_t;

  typedef struct packed {
    logic [15:0]                 debounce_ms;
    logic [TABLE_DIM-1:0][15:0] column_pin;
  } cfg_t;

  localparam logic MODE_EVENT = 1'b0;
  localparam logic MODE_POLL  = 1'b1;

  function automatic logic [7:0] key_char(input logic [1:0] row, input logic [1:0] col);
    logic [7:0] ch;
    unique case ({row, col})
      4'h0: ch = "1";
      4'h1: ch = "2";
      4'h2: ch = "3";
      4'h3: ch = "A";
      4'h4: ch = "4";
      4'h5: ch = "5";
      4'h6: ch = "6";
      4'h7: ch = "B";
      4'h8: ch = "7";
      4'h9: ch = "8";
      4'ha: ch = "9";
      4'hb: ch = "C";
      4'hc: ch = "*";
      4'hd: ch = "0";
      4'he: ch = "#";
      4'hf: ch = "D";
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/core/matrix_keypad_scanner_unit.sv
`timescale 1ns / 1ps
// Keypad qualifier for a 4x4 matrix: column events are debounced against the last
// accepted event time and latch a column, polls turn the latched column and the
// first low row into an ASCII key code. One transaction is accepted every cycle
// while out_ready does not stall the output; each result passes through the input
// register and then the result register, and the scan state is updated as an item
// moves from the input register to the result register, so back-to-back items see
// the effect of the one before. Configuration writes take effect on the next cycle
// and should be made only while no transaction is in flight.
`include "matrix_keypad_scanner_unit_defines.svh"
module matrix_keypad_scanner_unit
  import mks_pkg::*;
#(
  parameter int ROW_COUNT    = 4,
  parameter int COLUMN_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  in_t  s1_item;
  logic s1_valid;
  logic s1_fire;
  out_t result;

  mks_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mks_qualify #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_qualify (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_fire),
    .item   (s1_item),
    .cfg    (cfg),
    .result (result)
  );

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

  `MKS_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_fire, s1_valid && $stable(s1_item), "stalled item lost")
  `MKS_ASSERT_NOW(a_kind_excl, out_valid, !(out_data.event_taken && out_data.key_valid), "event and key in one result")
  `MKS_ASSERT_NOW(a_taken_pend, out_valid && out_data.event_taken, out_data.key_pending, "taken event not pending")
  `MKS_ASSERT_NOW(a_key_clears, out_valid && out_data.key_valid, !out_data.key_pending, "key left pending")
  `MKS_ASSERT_NOW(a_code_valid, out_valid, (out_data.key_code != 8'd0) == out_data.key_valid, "key code mismatch")

endmodule

// File: rtl/core/mks_cfg_regs.sv
`timescale 1ns / 1ps
module mks_cfg_regs
  import mks_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms <= DEBOUNCE_MS_RESET;
      cfg.column_pin  <= COLUMN_PIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE_MS:      cfg.debounce_ms   <= cfg_data;
        REG_COLUMN_PIN_ZERO:  cfg.column_pin[0] <= cfg_data;
        REG_COLUMN_PIN_ONE:   cfg.column_pin[1] <= cfg_data;
        REG_COLUMN_PIN_TWO:   cfg.column_pin[2] <= cfg_data;
        REG_COLUMN_PIN_THREE: cfg.column_pin[3] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/mks_qualify.sv
`timescale 1ns / 1ps
module mks_qualify
  import mks_pkg::*;
#(
  parameter int ROW_COUNT    = 4,
  parameter int COLUMN_COUNT = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  in_t  item,
  input  cfg_t cfg,
  output out_t result
);

  localparam int ROWS_USED = (ROW_COUNT < TABLE_DIM) ? ROW_COUNT : TABLE_DIM;
  localparam int COLS_USED = (COLUMN_COUNT < TABLE_DIM) ? COLUMN_COUNT : TABLE_DIM;

  logic [31:0] last_event_time, last_event_time_next;
  logic        pending_mark, pending_mark_next;
  logic [1:0]  latched_column, latched_column_next;

  logic [31:0] elapsed;
  logic        debounce_ok;
  logic        col_found;
  logic [1:0]  col_hit;
  logic        row_found;
  logic [1:0]  row_hit;

  assign elapsed     = item.time_ms - last_event_time;
  assign debounce_ok = elapsed >= {16'd0, cfg.debounce_ms};

  // lowest matching column
  always_comb begin
    col_found = 1'b0;
    col_hit   = '0;
    for (int c = 0; c < COLS_USED; c++) begin
      if (!col_found && item.pin_code == cfg.column_pin[c]) begin
        col_found = 1'b1;
        col_hit   = 2'(c);
      end
    end
  end

  // lowest row reading low
  always_comb begin
    row_found = 1'b0;
    row_hit   = '0;
    for (int r = 0; r < ROWS_USED; r++) begin
      if (!row_found && !item.row_sense[r]) begin
        row_found = 1'b1;
        row_hit   = 2'(r);
      end
    end
  end

  always_comb begin
    last_event_time_next = last_event_time;
    pending_mark_next    = pending_mark;
    latched_column_next  = latched_column;
    result               = '0;
    if (item.mode == MODE_EVENT) begin
      if (debounce_ok) begin
        last_event_time_next = item.time_ms;
        if (!pending_mark && col_found) begin
          latched_column_next = col_hit;
          pending_mark_next   = 1'b1;
          result.event_taken  = 1'b1;
        end
      end
    end else if (pending_mark) begin
      if (row_found) begin
        result.key_valid = 1'b1;
        result.key_code  = key_char(row_hit, latched_column);
      end
      pending_mark_next = 1'b0;
    end
    result.key_pending = pending_mark_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_event_time <= '0;
      pending_mark    <= 1'b0;
      latched_column  <= '0;
    end else if (fire) begin
      last_event_time <= last_event_time_next;
      pending_mark    <= pending_mark_next;
      latched_column  <= latched_column_next;
    end
  end

endmodule
